/* rtl/tbnr_pkg.sv */
// ----------------------------------------------------------------------------
// tbnr_pkg
// Shared types and constants of the text normalize and replace core.
// ----------------------------------------------------------------------------
package tbnr_pkg;

    localparam logic [1:0] CMD_TEXT = 2'd0;
    localparam logic [1:0] CMD_PAT  = 2'd1;
    localparam logic [1:0] CMD_REP  = 2'd2;
    localparam logic [1:0] CMD_RUN  = 2'd3;

    localparam logic [1:0] OP_COUNT   = 2'd0;
    localparam logic [1:0] OP_REVERSE = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PAD   = 8'h2E;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [5:0] num_words;
        logic       status;
        logic       last;
    } result_t;

    // Classified item as it waits in the queue.
    typedef struct packed {
        logic [1:0] command;
        logic       blank;
        logic [7:0] data_byte;
    } entry_t;

endpackage

/* rtl/tbnr_front.sv */
// ----------------------------------------------------------------------------
// tbnr_front
// Accepts items, marks blanks and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tbnr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tbnr_pkg::item_t item,
    input  logic            pop,
    output logic            avail,
    output tbnr_pkg::entry_t entry
);
    import tbnr_pkg::*;

    entry_t     q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    entry_t     new_entry;

    assign busy  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign push  = start && !busy;
    assign entry = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.command   = item.command;
        new_entry.data_byte = item.data_byte;
        new_entry.blank     = (item.data_byte == CH_SPACE) || (item.data_byte == CH_TAB);
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* rtl/tbnr_back.sv */
// ----------------------------------------------------------------------------
// tbnr_back
// Holds the stores, loads bytes and carries out the run and the emission.
// ----------------------------------------------------------------------------
module tbnr_back #(
    parameter int BUF_SIZE = 64,
    parameter int PAT_MAX  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        operation,
    input  logic              avail,
    input  tbnr_pkg::entry_t  entry,
    output logic              pop,
    output logic              result_valid,
    output tbnr_pkg::result_t result
);
    import tbnr_pkg::*;

    localparam int LW  = $clog2(BUF_SIZE + 1);
    localparam int AW  = $clog2(BUF_SIZE);
    localparam int PLW = $clog2(PAT_MAX + 1);
    localparam int PW  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int SW  = ((LW > PLW) ? LW : PLW) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RTOP  = 3'd1;
    localparam logic [2:0] S_RCOPY = 3'd2;
    localparam logic [2:0] S_RCMP  = 3'd3;
    localparam logic [2:0] S_RREP  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [LW-1:0] BUF_LEN  = LW'(BUF_SIZE);
    localparam logic [LW-1:0] BUF_LAST = LW'(BUF_SIZE - 1);
    localparam logic [SW-1:0] BUF_SUM  = SW'(BUF_SIZE);
    localparam logic [PLW-1:0] PAT_LEN = PLW'(PAT_MAX);

    logic [7:0] txt_mem [BUF_SIZE];
    logic [7:0] scr_mem [BUF_SIZE];
    logic [7:0] pat_reg [PAT_MAX];
    logic [7:0] rep_reg [PAT_MAX];

    logic [2:0]     state_reg, state_next;
    logic [LW-1:0]  txt_len_reg, txt_len_next;
    logic           last_sp_reg, last_sp_next;
    logic [LW-1:0]  words_reg, words_next;
    logic           ovf_reg, ovf_next;
    logic [PLW-1:0] pat_len_reg, pat_len_next;
    logic [PLW-1:0] rep_len_reg, rep_len_next;
    logic [LW-1:0]  j_reg, j_next;
    logic [LW-1:0]  n_reg, n_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [LW-1:0]  k_reg, k_next;
    logic           src_reg, src_next;
    logic           rev_reg, rev_next;
    logic [5:0]     wc_reg, wc_next;
    logic           ov_reg, ov_next;
    logic           err_reg, err_next;
    logic           pad_reg, pad_next;
    logic           lst_reg, lst_next;

    logic [7:0]    txt_rd_reg;
    logic [7:0]    scr_rd_reg;
    logic [AW-1:0] txt_raddr;
    logic          txt_we;
    logic [7:0]    txt_wdata;
    logic          scr_we;
    logic [7:0]    scr_wdata;
    logic          pat_we;
    logic          rep_we;
    logic          app;
    logic [7:0]    app_byte;
    logic          clr;
    logic [SW-1:0] jp_sum;
    logic [SW-1:0] np_sum;
    logic [PW-1:0] kp;

    assign jp_sum = SW'(j_reg) + SW'(pat_len_reg);
    assign np_sum = SW'(n_reg) + SW'(pat_len_reg);
    assign kp     = k_reg[PW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        txt_len_next = txt_len_reg;
        last_sp_next = last_sp_reg;
        words_next   = words_reg;
        ovf_next     = ovf_reg;
        pat_len_next = pat_len_reg;
        rep_len_next = rep_len_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        rev_next     = rev_reg;
        wc_next      = wc_reg;
        ov_next      = 1'b0;
        err_next     = 1'b0;
        pad_next     = pad_reg;
        lst_next     = 1'b0;
        txt_raddr    = j_reg[AW-1:0];
        txt_we       = 1'b0;
        txt_wdata    = entry.data_byte;
        scr_we       = 1'b0;
        scr_wdata    = txt_rd_reg;
        pat_we       = 1'b0;
        rep_we       = 1'b0;
        app          = 1'b0;
        app_byte     = entry.data_byte;
        clr          = 1'b0;
        pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop = 1'b1;
                    case (entry.command)
                        CMD_TEXT:
                        begin
                            if (!ovf_reg)
                            begin
                                if (entry.blank)
                                begin
                                    app      = (txt_len_reg != '0) && !last_sp_reg;
                                    app_byte = CH_SPACE;
                                end
                                else
                                begin
                                    app = 1'b1;
                                end
                            end
                        end
                        CMD_PAT:
                        begin
                            if (pat_len_reg < PAT_LEN)
                            begin
                                pat_we       = 1'b1;
                                pat_len_next = pat_len_reg + 1'b1;
                            end
                        end
                        CMD_REP:
                        begin
                            if (rep_len_reg < PAT_LEN)
                            begin
                                rep_we       = 1'b1;
                                rep_len_next = rep_len_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (ovf_reg)
                            begin
                                ov_next  = 1'b1;
                                err_next = 1'b1;
                                wc_next  = 6'd0;
                                clr      = 1'b1;
                            end
                            else
                            begin
                                // The trailing space, if any, is dropped here.
                                len_next = txt_len_reg - {{(LW-1){1'b0}}, last_sp_reg};
                                wc_next  = words_reg[5:0];
                                j_next   = '0;
                                n_next   = '0;
                                k_next   = '0;
                                if (operation == OP_REPLACE && pat_len_reg != '0)
                                begin
                                    src_next   = 1'b1;
                                    rev_next   = 1'b0;
                                    state_next = S_RTOP;
                                end
                                else
                                begin
                                    src_next   = 1'b0;
                                    rev_next   = (operation == OP_REVERSE);
                                    state_next = S_EMIT;
                                end
                            end
                        end
                    endcase
                end
            end
            S_RTOP:
            begin
                txt_raddr = j_reg[AW-1:0];
                if (j_reg >= len_reg || n_reg >= BUF_LEN)
                begin
                    len_next   = n_reg;
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else if (jp_sum <= SW'(len_reg) && np_sum <= BUF_SUM)
                begin
                    k_next     = '0;
                    state_next = S_RCMP;
                end
                else
                begin
                    state_next = S_RCOPY;
                end
            end
            S_RCOPY:
            begin
                scr_we     = 1'b1;
                scr_wdata  = txt_rd_reg;
                n_next     = n_reg + 1'b1;
                j_next     = j_reg + 1'b1;
                state_next = S_RTOP;
            end
            S_RCMP:
            begin
                if (txt_rd_reg != pat_reg[kp])
                begin
                    txt_raddr  = j_reg[AW-1:0];
                    state_next = S_RCOPY;
                end
                else if (SW'(k_reg) + SW'(1) == SW'(pat_len_reg))
                begin
                    k_next     = '0;
                    state_next = S_RREP;
                end
                else
                begin
                    k_next    = k_reg + 1'b1;
                    txt_raddr = AW'(j_reg + k_reg + 1'b1);
                end
            end
            S_RREP:
            begin
                if (SW'(k_reg) < SW'(rep_len_reg) && n_reg < BUF_LEN)
                begin
                    scr_we    = 1'b1;
                    scr_wdata = rep_reg[kp];
                    n_next    = n_reg + 1'b1;
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    j_next     = LW'(jp_sum);
                    state_next = S_RTOP;
                end
            end
            S_EMIT:
            begin
                txt_raddr = rev_reg ? AW'(len_reg - 1'b1 - k_reg) : k_reg[AW-1:0];
                ov_next   = 1'b1;
                pad_next  = (k_reg >= len_reg);
                lst_next  = (k_reg == BUF_LAST);
                k_next    = k_reg + 1'b1;
                if (k_reg == BUF_LAST)
                begin
                    clr        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (app)
        begin
            txt_wdata = app_byte;
            if (txt_len_reg == BUF_LEN)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                txt_we       = 1'b1;
                txt_len_next = txt_len_reg + 1'b1;
                last_sp_next = (app_byte == CH_SPACE);
                if (app_byte != CH_SPACE && (txt_len_reg == '0 || last_sp_reg))
                begin
                    words_next = words_reg + 1'b1;
                end
            end
        end

        if (clr)
        begin
            txt_len_next = '0;
            last_sp_next = 1'b0;
            words_next   = '0;
            ovf_next     = 1'b0;
            pat_len_next = '0;
            rep_len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            txt_len_reg <= '0;
            last_sp_reg <= 1'b0;
            words_reg   <= '0;
            ovf_reg     <= 1'b0;
            pat_len_reg <= '0;
            rep_len_reg <= '0;
            ov_reg      <= 1'b0;
            err_reg     <= 1'b0;
            lst_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            txt_len_reg <= txt_len_next;
            last_sp_reg <= last_sp_next;
            words_reg   <= words_next;
            ovf_reg     <= ovf_next;
            pat_len_reg <= pat_len_next;
            rep_len_reg <= rep_len_next;
            ov_reg      <= ov_next;
            err_reg     <= err_next;
            lst_reg     <= lst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        n_reg   <= n_next;
        len_reg <= len_next;
        k_reg   <= k_next;
        src_reg <= src_next;
        rev_reg <= rev_next;
        wc_reg  <= wc_next;
        pad_reg <= pad_next;
        if (pat_we)
        begin
            pat_reg[pat_len_reg[PW-1:0]] <= entry.data_byte;
        end
        if (rep_we)
        begin
            rep_reg[rep_len_reg[PW-1:0]] <= entry.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_len_reg[AW-1:0]] <= txt_wdata;
        end
        txt_rd_reg <= txt_mem[txt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr_mem[n_reg[AW-1:0]] <= scr_wdata;
        end
        scr_rd_reg <= scr_mem[k_reg[AW-1:0]];
    end

    always_comb
    begin
        result_valid = ov_reg;
        if (err_reg)
        begin
            result.out_byte = 8'd0;
        end
        else if (pad_reg)
        begin
            result.out_byte = CH_PAD;
        end
        else
        begin
            result.out_byte = src_reg ? scr_rd_reg : txt_rd_reg;
        end
        result.num_words = wc_reg;
        result.status    = err_reg;
        result.last      = lst_reg || err_reg;
    end

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        txt_len_reg <= BUF_LEN)
        else $error("text length beyond buffer");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> (state_reg == S_IDLE))
        else $error("last result while run still active");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped during run");

    a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |=> result_valid)
        else $error("emission cycle gave no result");
`endif

endmodule

/* rtl/text_buffer_normalize_replace_core.sv */
// ----------------------------------------------------------------------------
// text_buffer_normalize_replace_core
// Whitespace-normalizing text buffer with word count, reverse and replace.
// ----------------------------------------------------------------------------
// Load items (text, pattern and replacement bytes) pass a two-entry queue and
// are absorbed at one per cycle, so start may be held high while busy is low.
// A run item is taken from the queue in the idle state, and no further item is
// taken while its walk or emission is in progress. With replace and a pattern
// loaded, a walk over the text comes first, through the single read port of the
// text memory: each text position has its byte fetched and, where the pattern
// fits, compared byte by byte with it; an unmatched byte is then copied to the
// scratch memory, a match writes the replacement bytes and skips the pattern, and a final check
// closes the walk. Results come out one per cycle, BUF_SIZE of them (one if
// the text overflowed), with result_valid high for exactly one cycle each; the
// receiver cannot stall them and must take every one.
module text_buffer_normalize_replace_core #(
    parameter int BUF_SIZE = 64,
    parameter int PAT_MAX  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tbnr_pkg::item_t   item,
    output logic              result_valid,
    output tbnr_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);
    import tbnr_pkg::*;

    logic [1:0] op_val_reg;
    logic [1:0] op_val_next;
    logic       pop;
    logic       avail;
    entry_t     entry;

    assign cfg_ready   = 1'b1;
    assign op_val_next = (cfg_valid && cfg_ready) ? cfg_data : op_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_val_reg <= OP_COUNT;
        end
        else
        begin
            op_val_reg <= op_val_next;
        end
    end

    tbnr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .pop   (pop),
        .avail (avail),
        .entry (entry)
    );

    tbnr_back #(
        .BUF_SIZE (BUF_SIZE),
        .PAT_MAX  (PAT_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (op_val_reg),
        .avail        (avail),
        .entry        (entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* dv/text_buffer_normalize_replace_core_tb.sv */
// ----------------------------------------------------------------------------
// text_buffer_normalize_replace_core_tb
// Drives text, pattern, replacement and run items into the core and predicts
// each emitted buffer byte, word count, status and last flag. Each result is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module text_buffer_normalize_replace_core_tb;
    import tbnr_pkg::*;

    localparam int BUF_SIZE = 64;
    localparam int PAT_MAX  = 16;
    localparam int CYCLE_LIMIT = 2000000;

    // Operation code with no defined meaning; the core treats it as count only.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_valid;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [1:0] cfg_data;

    // Predictor state.
    logic [7:0] text_mem [BUF_SIZE];
    int         text_len;
    logic [7:0] pat_mem [PAT_MAX];
    int         pat_len;
    logic [7:0] rep_mem [PAT_MAX];
    int         rep_len;
    logic       overflowed;
    logic [1:0] op_mode;

    result_t expected_results [$];
    int      error_count;
    int      cycle_count;
    logic    quiet;

    text_buffer_normalize_replace_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    // Runs the operation on the loaded text and queues the emitted bytes.
    task automatic predict_run();
        logic [7:0] buf_q [$];
        logic [7:0] grown [$];
        int         len;
        int         words;
        bit         in_word;
        bit         hit;
        int         i;
        result_t    r;
        begin
            if (overflowed)
            begin
                r = '{out_byte: 8'd0, num_words: 6'd0, status: 1'b1, last: 1'b1};
                expected_results.push_back(r);
            end
            else
            begin
                len = text_len;
                for (int k = 0; k < len; k++)
                    buf_q.push_back(text_mem[k]);
                if (len > 0 && buf_q[len-1] == CH_SPACE)
                begin
                    void'(buf_q.pop_back());
                    len--;
                end
                words = 0;
                in_word = 0;
                for (int k = 0; k < len; k++)
                begin
                    if (buf_q[k] != CH_SPACE)
                    begin
                        if (!in_word)
                            words++;
                        in_word = 1;
                    end
                    else
                        in_word = 0;
                end
                if (op_mode == OP_REVERSE)
                    buf_q.reverse();
                else if (op_mode == OP_REPLACE)
                begin
                    i = 0;
                    while (i < buf_q.size())
                    begin
                        hit = pat_len > 0 && i + pat_len <= buf_q.size();
                        for (int k = 0; hit && k < pat_len; k++)
                            if (buf_q[i+k] != pat_mem[k])
                                hit = 0;
                        if (hit)
                        begin
                            grown = {};
                            for (int k = 0; k < i; k++)
                                grown.push_back(buf_q[k]);
                            for (int k = 0; k < rep_len && grown.size() < BUF_SIZE; k++)
                                grown.push_back(rep_mem[k]);
                            for (int k = i + pat_len;
                                 k < buf_q.size() && grown.size() < BUF_SIZE; k++)
                                grown.push_back(buf_q[k]);
                            buf_q = grown;
                            i += rep_len;
                        end
                        else
                            i++;
                    end
                end
                for (int k = 0; k < BUF_SIZE; k++)
                begin
                    r.out_byte  = (k < buf_q.size()) ? buf_q[k] : CH_PAD;
                    r.num_words = words[5:0];
                    r.status    = 1'b0;
                    r.last      = (k == BUF_SIZE - 1);
                    expected_results.push_back(r);
                end
            end
            text_len = 0;
            pat_len = 0;
            rep_len = 0;
            overflowed = 0;
        end
    endtask

    task automatic predict_item(item_t it);
        begin
            case (it.command)
                CMD_TEXT:
                    if (!overflowed)
                    begin
                        if (!is_blank(it.data_byte) ||
                            (text_len > 0 && text_mem[text_len-1] != CH_SPACE))
                        begin
                            if (text_len >= BUF_SIZE)
                                overflowed = 1;
                            else
                            begin
                                text_mem[text_len] = is_blank(it.data_byte) ?
                                                     CH_SPACE : it.data_byte;
                                text_len++;
                            end
                        end
                    end
                CMD_PAT:
                    if (pat_len < PAT_MAX)
                    begin
                        pat_mem[pat_len] = it.data_byte;
                        pat_len++;
                    end
                CMD_REP:
                    if (rep_len < PAT_MAX)
                    begin
                        rep_mem[rep_len] = it.data_byte;
                        rep_len++;
                    end
                default:
                    predict_run();
            endcase
        end
    endtask

    // Sends one item, with a random gap unless the quiet stretch is on.
    // Drives are applied at the falling edge, away from the sampling edge.
    task automatic send_item(logic [1:0] cmd, logic [7:0] b);
        item_t it;
        begin
            while (!quiet && $urandom_range(99) < 27)
            begin
                start = 1'b0;
                @(negedge clk);
            end
            it.command = cmd;
            it.data_byte = b;
            start = 1'b1;
            item  = it;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_item(it);
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic send_string(string s);
        begin
            for (int k = 0; k < s.len(); k++)
                send_item(CMD_TEXT, s[k]);
        end
    endtask

    task automatic send_pattern(string p, string rpl);
        begin
            for (int k = 0; k < p.len(); k++)
                send_item(CMD_PAT, p[k]);
            for (int k = 0; k < rpl.len(); k++)
                send_item(CMD_REP, rpl[k]);
        end
    endtask

    // Waits for all results plus a margin, then writes the operation register.
    task automatic write_operation(logic [1:0] value);
        begin
            while (expected_results.size() != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            op_mode = value;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic test_count_words();
        begin
            write_operation(OP_COUNT);
            send_string("\t  hello \t world  ");
            send_item(CMD_RUN, 8'hFF);
            send_item(CMD_RUN, 8'h00);
            send_item(CMD_TEXT, 8'h00);
            send_item(CMD_TEXT, 8'hFF);
            send_item(CMD_RUN, 8'h00);
        end
    endtask

    task automatic test_reverse();
        begin
            write_operation(OP_REVERSE);
            send_string("ab cd e ");
            send_item(CMD_RUN, 8'h00);
        end
    endtask

    task automatic test_replace();
        begin
            write_operation(OP_REPLACE);
            send_pattern("aa", "xaay");
            send_string("aaa aa");
            send_item(CMD_RUN, 8'h00);
            send_string("abc");
            send_item(CMD_RUN, 8'h00);
        end
    endtask

    task automatic test_overflow_and_growth();
        begin
            write_operation(OP_COUNT);
            for (int k = 0; k < BUF_SIZE + 2; k++)
                send_item(CMD_TEXT, 8'(8'h41 + (k % 26)));
            send_item(CMD_RUN, 8'h00);
            write_operation(OP_RESERVED);
            send_string("q w");
            send_item(CMD_RUN, 8'h00);
            write_operation(OP_REPLACE);
            send_pattern("b", "0123456789abcdefXY");
            for (int k = 0; k < 20; k++)
                send_item(CMD_TEXT, 8'h62);
            send_item(CMD_RUN, 8'h00);
        end
    endtask

    // Well-formed runs with random text from a small alphabet, plus noise.
    task automatic test_random();
        int  sent;
        int  n;
        logic [7:0] b;
        begin
            sent = 0;
            while (sent < 250)
            begin
                write_operation(2'($urandom_range(3)));
                quiet = (sent >= 80 && sent < 160);
                n = $urandom_range(3);
                for (int k = 0; k < n; k++)
                begin
                    send_item(CMD_PAT, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                                 : 8'(8'h61 + $urandom_range(2)));
                    sent++;
                end
                n = $urandom_range(4);
                for (int k = 0; k < n; k++)
                begin
                    send_item(CMD_REP, 8'($urandom_range(255)));
                    sent++;
                end
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(24);
                for (int k = 0; k < n; k++)
                begin
                    case ($urandom_range(5))
                        0: b = CH_SPACE;
                        1: b = CH_TAB;
                        2: b = 8'($urandom_range(255));
                        default: b = 8'(8'h61 + $urandom_range(2));
                    endcase
                    send_item(CMD_TEXT, b);
                    sent++;
                end
                send_item(CMD_RUN, 8'($urandom_range(255)));
                sent++;
            end
            quiet = 0;
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", result);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.out_byte !== exp_r.out_byte)
                begin
                    $error("out_byte expected %h actual %h", exp_r.out_byte, result.out_byte);
                    error_count++;
                end
                if (result.num_words !== exp_r.num_words)
                begin
                    $error("num_words expected %0d actual %0d",
                           exp_r.num_words, result.num_words);
                    error_count++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status expected %b actual %b", exp_r.status, result.status);
                    error_count++;
                end
                if (result.last !== exp_r.last)
                begin
                    $error("last expected %b actual %b", exp_r.last, result.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 0;
        error_count = 0;
        cycle_count = 0;
        text_len = 0;
        pat_len = 0;
        rep_len = 0;
        overflowed = 0;
        op_mode = OP_COUNT;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_count_words();
        test_reverse();
        test_replace();
        test_overflow_and_growth();
        test_random();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

/* sim.f */
rtl/tbnr_pkg.sv
rtl/tbnr_front.sv
rtl/tbnr_back.sv
rtl/text_buffer_normalize_replace_core.sv
dv/text_buffer_normalize_replace_core_tb.sv
